>>> src/pidaw_pkg.sv
package pidaw_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int ERR_W          = SAMPLE_BITS + 1;
  localparam int SUM_W          = 48;
  localparam int WIDE_W         = 64;
  localparam int DIV_W          = 40;
  localparam int DEN_W          = 24;
  localparam int DIV_CNT_W      = $clog2(DIV_W + 1);

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic wide_t clamp_sym(input wide_t v, input wide_t lim);
    wide_t r;
    r = v;
    if (lim > 0) begin
      if (v > lim) begin
        r = lim;
      end else if (v < -lim) begin
        r = -lim;
      end
    end
    return r;
  endfunction

endpackage

>>> src/pid_controller_antiwindup.sv
// An item inside the deadband goes from evaluation straight to the result. Otherwise the controller
// runs the proportional, derivative and integral steps on the shared 24x24 multiplier, with a serial
// derivative division when elapsed_ticks is nonzero, the integral update, the anti-windup check of the
// trial output, and the integral clamp division (ki positive and i_limit nonzero) where they apply.
// One item at a time; the next item is taken once the result has left and the block is idle again.
// Reset clears the configuration, the state, the stored errors and the error sum, not the datapath.
module pid_controller_antiwindup (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] target,
  input  logic signed [15:0] measured,
  input  logic [15:0] elapsed_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] drive,
  output logic signed [16:0] error_now,
  output logic signed [47:0] integral_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [46:0] cfg_data
);
  import pidaw_pkg::*;

  localparam logic [3:0] R_KP = 4'd0, R_KI = 4'd1, R_KD = 4'd2, R_OLIM = 4'd3,
                         R_ILIM = 4'd4, R_FLOOR = 4'd5, R_AW = 4'd6, R_DB = 4'd7;

  localparam logic [4:0] S_IDLE = 5'd0, S_EVAL = 5'd1, S_PTERM = 5'd2, S_EDT = 5'd3,
                         S_DPROD = 5'd4, S_DDIV = 5'd5, S_INTEG = 5'd6, S_SMLO = 5'd7,
                         S_SMHI = 5'd8, S_SMFIN = 5'd9, S_TRIAL = 5'd10, S_CLAMPI = 5'd11,
                         S_IDIV = 5'd12, S_FLOOR = 5'd13, S_ITERM = 5'd14, S_ROUND = 5'd15,
                         S_OUT = 5'd16;

  localparam wide_t SAT_BIG = wide_t'(1) <<< 60;
  localparam wide_t DMAX    = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam wide_t HALF    = wide_t'(1) <<< (GAIN_FRAC_BITS - 1);

  logic signed [23:0] kp, ki, kd;
  logic [14:0]        out_limit, i_limit;
  logic [46:0]        integral_floor;
  logic               anti_windup_on;
  logic [15:0]        deadband;

  logic [4:0]              state;
  logic signed [ERR_W-1:0] e, previous_error, last_error;
  logic [15:0]             dt;
  logic signed [SUM_W-1:0] error_sum, es_new, es_work, sm_src;
  logic                    sm_last, d_neg;
  wide_t                   pterm, dq, smul, sum;
  logic [47:0]             mul_a_p, sm_lo;
  logic [23:0]             mul_a, mul_b;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [ERR_W-1:0]        ae;
  logic signed [ERR_W:0]   d;
  logic [ERR_W:0]          ad;
  logic [23:0]             akp, aki, akd;
  logic [SUM_W-1:0]        mb;
  wide_t                   olim, ilim, trial, dterm, sum_c, s2, drv;
  logic [71:0]             full;
  wide_t                   smag, smul_c;
  logic signed [SUM_W:0]   es_add;
  logic signed [SUM_W-1:0] es_sat, es_ic, es_fl, neg_floor, bnd;
  logic signed [34:0]      edt;
  logic                    integ;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0; ki <= '0; kd <= '0;
      out_limit <= '0; i_limit <= '0; integral_floor <= '0;
      anti_windup_on <= 1'b0; deadband <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        R_KP:    kp <= cfg_data[23:0];
        R_KI:    ki <= cfg_data[23:0];
        R_KD:    kd <= cfg_data[23:0];
        R_OLIM:  out_limit <= cfg_data[14:0];
        R_ILIM:  i_limit <= cfg_data[14:0];
        R_FLOOR: integral_floor <= cfg_data;
        R_AW:    anti_windup_on <= cfg_data[0];
        R_DB:    deadband <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign ae  = e[ERR_W-1] ? ERR_W'(-e) : e;
  assign d   = {e[ERR_W-1], e} - {previous_error[ERR_W-1], previous_error};
  assign ad  = d[ERR_W] ? (ERR_W+1)'(-d) : d;
  assign akp = kp[23] ? 24'(-kp) : kp;
  assign aki = ki[23] ? 24'(-ki) : ki;
  assign akd = kd[23] ? 24'(-kd) : kd;
  assign mb  = sm_src[SUM_W-1] ? SUM_W'(-sm_src) : sm_src;
  assign olim = wide_t'({out_limit, 16'b0});
  assign ilim = wide_t'({i_limit, 16'b0});
  assign integ = (ki != 0) && (dt != 0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_EVAL:  begin mul_a = akp; mul_b = 24'(ae); end
      S_PTERM: begin mul_a = 24'(ae); mul_b = 24'(dt); end
      S_EDT:   begin mul_a = akd; mul_b = 24'(ad); end
      S_SMLO:  begin mul_a = aki; mul_b = mb[23:0]; end
      S_SMHI:  begin mul_a = aki; mul_b = mb[47:24]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_a_p <= mul_a * mul_b;
  end

  assign edt    = e[ERR_W-1] ? -35'(mul_a_p[33:0]) : 35'(mul_a_p[33:0]);
  assign es_add = {error_sum[SUM_W-1], error_sum} + (SUM_W+1)'(edt);
  assign es_sat = (es_add[SUM_W] != es_add[SUM_W-1])
                ? (es_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}})
                : es_add[SUM_W-1:0];

  assign full   = {mul_a_p, 24'b0} + 72'(sm_lo);
  assign smag   = (full > 72'(SAT_BIG)) ? SAT_BIG : wide_t'(full[62:0]);
  assign smul_c = (ki[23] ^ sm_src[SUM_W-1]) ? -smag : smag;

  assign trial = pterm + smul + dq;

  assign bnd   = SUM_W'(div_rsp.quotient);
  always_comb begin
    es_ic = es_work;
    if (bnd != 0) begin
      if (es_work > bnd) begin
        es_ic = bnd;
      end else if (es_work < -bnd) begin
        es_ic = -bnd;
      end
    end
  end

  assign neg_floor = -SUM_W'(integral_floor);
  assign es_fl = ((integral_floor != 0) && (es_work < neg_floor)) ? neg_floor : es_work;

  assign dterm = ((kd != 0) && (dt != 0)) ? clamp_sym(dq, olim) : '0;
  assign sum_c = clamp_sym(pterm + clamp_sym(smul, ilim) + dterm, olim);
  assign s2    = sum + HALF;
  assign drv   = clamp_sym(s2 >>> GAIN_FRAC_BITS, DMAX);

  always_comb begin
    div_req = '0;
    if (state == S_DPROD && dt != 0) begin
      div_req.start    = 1'b1;
      div_req.dividend = mul_a_p[DIV_W-1:0];
      div_req.divisor  = DEN_W'(dt);
    end else if (state == S_CLAMPI && !ki[23] && ki != 0 && i_limit != 0) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'({i_limit, 16'b0});
      div_req.divisor  = ki;
    end
  end

  pidaw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      previous_error <= '0;
      last_error     <= '0;
      error_sum      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            e     <= ERR_W'(target) - ERR_W'(measured);
            dt    <= elapsed_ticks;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (ae < {1'b0, deadband}) begin
            drive        <= '0;
            error_now    <= last_error;
            integral_now <= error_sum;
            state        <= S_OUT;
          end else begin
            state <= S_PTERM;
          end
        end
        S_PTERM: begin
          pterm <= clamp_sym((kp[23] ^ e[ERR_W-1]) ? -wide_t'(mul_a_p) : wide_t'(mul_a_p),
                             olim);
          state <= S_EDT;
        end
        S_EDT: begin
          es_new <= es_sat;
          state  <= S_DPROD;
        end
        S_DPROD: begin
          d_neg <= kd[23] ^ d[ERR_W];
          if (dt != 0) begin
            state <= S_DDIV;
          end else begin
            dq    <= '0;
            state <= S_INTEG;
          end
        end
        S_DDIV: begin
          if (div_rsp.done) begin
            dq    <= d_neg ? -wide_t'(div_rsp.quotient) : wide_t'(div_rsp.quotient);
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (integ) begin
            es_work <= es_new;
            if (anti_windup_on && out_limit != 0) begin
              sm_src  <= es_new;
              sm_last <= 1'b0;
              state   <= S_SMLO;
            end else begin
              state <= S_CLAMPI;
            end
          end else begin
            sm_src  <= error_sum;
            sm_last <= 1'b1;
            state   <= S_SMLO;
          end
        end
        S_SMLO: state <= S_SMHI;
        S_SMHI: begin
          sm_lo <= mul_a_p;
          state <= S_SMFIN;
        end
        S_SMFIN: begin
          smul  <= smul_c;
          state <= sm_last ? S_ITERM : S_TRIAL;
        end
        S_TRIAL: begin
          if ((trial >= olim && !e[ERR_W-1] && e != 0) || (trial <= -olim && e[ERR_W-1])) begin
            es_work <= error_sum;
          end
          state <= S_CLAMPI;
        end
        S_CLAMPI: begin
          state <= (!ki[23] && ki != 0 && i_limit != 0) ? S_IDIV : S_FLOOR;
        end
        S_IDIV: begin
          if (div_rsp.done) begin
            es_work <= es_ic;
            state   <= S_FLOOR;
          end
        end
        S_FLOOR: begin
          error_sum <= es_fl;
          sm_src    <= es_fl;
          sm_last   <= 1'b1;
          state     <= S_SMLO;
        end
        S_ITERM: begin
          sum   <= sum_c;
          state <= S_ROUND;
        end
        S_ROUND: begin
          drive          <= drv[15:0];
          error_now      <= e;
          integral_now   <= error_sum;
          previous_error <= e;
          last_error     <= e;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/pidaw_div.sv
module pidaw_div (
  input  logic                clk,
  input  logic                rst,
  input  pidaw_pkg::div_req_t req,
  output pidaw_pkg::div_rsp_t rsp
);
  import pidaw_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic                 done;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
